FILE: sv/rsv_pkg.sv
// Package for the redundant sensor vote block: widths, register indexes, mode codes.
// Used by every module under sv/; depends on nothing.
package rsv_pkg;

    localparam int DATA_W      = 32;
    localparam int MAX_SRC     = 5;
    localparam int NUM_SOURCES = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CNT_W       = 3;

    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_CHECK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_VALUE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_READY = 3'd7;

    localparam logic [1:0] MODE_MEAN   = 2'd0;
    localparam logic [1:0] MODE_MEDIAN = 2'd1;
    localparam logic [1:0] MODE_MAX    = 2'd2;
    localparam logic [1:0] MODE_MIN    = 2'd3;

    localparam logic signed [DATA_W-1:0] HIGH_RESET     = 32'sd19660800;
    localparam logic signed [DATA_W-1:0] LOW_RESET      = 32'sd3276800;
    localparam logic signed [DATA_W-1:0] FALLBACK_RESET = 32'sd6553600;
    localparam logic signed [DATA_W-1:0] FORCE_RESET    = 32'sd13107200;

    // Per-lane findings handed to the merge stage
    typedef struct packed {
        logic                     keep;
        logic [CNT_W-1:0]         rank;
        logic signed [DATA_W-1:0] value;
    } lane_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic                     force_en;
        logic                     src_ready;
        logic signed [DATA_W-1:0] force_val;
        logic signed [DATA_W-1:0] fallback;
    } ctl_t;

endpackage

FILE: sv/rsv_lane.sv
// One lane: its reading's keep flag and its rank among the kept readings.
// Depends on rsv_pkg.
module rsv_lane #(
    parameter int LANE = 0
) (
    input  logic                                      keep_in [rsv_pkg::MAX_SRC],
    input  logic signed [rsv_pkg::DATA_W-1:0]         values  [rsv_pkg::MAX_SRC],
    output rsv_pkg::lane_t                            lane
);
    logic [rsv_pkg::CNT_W-1:0] rank;

    // Rank = kept readings that sort before this one; ties broken by index
    always_comb
    begin
        rank = '0;
        for (int j = 0; j < rsv_pkg::MAX_SRC; j++) begin
            if (j != LANE && keep_in[j]) begin
                if (values[j] < values[LANE] || (values[j] == values[LANE] && j < LANE)) begin
                    rank = rank + 1'b1;
                end
            end
        end
        lane.keep  = keep_in[LANE];
        lane.rank  = rank;
        lane.value = values[LANE];
    end
endmodule

FILE: sv/rsv_merge.sv
// Merge stage: picks min/max/median by rank, forms the mean sum, divides by count.
// Depends on rsv_pkg.
module rsv_merge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  rsv_pkg::lane_t                    lanes [rsv_pkg::MAX_SRC],
    input  rsv_pkg::ctl_t                     ctl,
    output logic signed [rsv_pkg::DATA_W-1:0] result
);
    localparam int SUM_W = rsv_pkg::DATA_W + 3;

    logic [rsv_pkg::CNT_W-1:0]         n;
    logic signed [rsv_pkg::DATA_W-1:0] lo_v, hi_v, mid_a, mid_b;
    logic signed [SUM_W-1:0]           sum;

    // Second stage registers
    logic [1:0]                        mode_reg;
    logic                              ovr_reg;
    logic signed [rsv_pkg::DATA_W-1:0] ovr_val_reg;
    logic [rsv_pkg::CNT_W-1:0]         n_reg;
    logic signed [rsv_pkg::DATA_W-1:0] lo_reg, hi_reg, mida_reg, midb_reg;
    logic signed [SUM_W-1:0]           sum_reg;

    always_comb
    begin
        n     = '0;
        sum   = '0;
        for (int i = 0; i < rsv_pkg::MAX_SRC; i++) begin
            if (lanes[i].keep) begin
                n   = n + 1'b1;
                sum = sum + SUM_W'(lanes[i].value);
            end
        end
        lo_v  = ctl.fallback;
        hi_v  = ctl.fallback;
        mid_a = ctl.fallback;
        mid_b = ctl.fallback;
        for (int i = 0; i < rsv_pkg::MAX_SRC; i++) begin
            if (lanes[i].keep) begin
                if (lanes[i].rank == '0) lo_v = lanes[i].value;
                if (lanes[i].rank == n - 1'b1) hi_v = lanes[i].value;
                if (lanes[i].rank == (n - 1'b1) >> 1) mid_a = lanes[i].value;
                if (lanes[i].rank == n >> 1) mid_b = lanes[i].value;
            end
        end
        if (n == '0) begin
            sum = SUM_W'(ctl.fallback);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= rsv_pkg::MODE_MEAN;
            ovr_reg  <= 1'b0;
        end else if (adv) begin
            mode_reg <= ctl.mode;
            ovr_reg  <= ctl.force_en | ~ctl.src_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            ovr_val_reg <= ctl.force_en ? ctl.force_val : '0;
            n_reg       <= (n == '0) ? rsv_pkg::CNT_W'(1) : n;
            lo_reg      <= lo_v;
            hi_reg      <= hi_v;
            mida_reg    <= mid_a;
            midb_reg    <= mid_b;
            sum_reg     <= sum;
        end
    end

    // Mean by constant divisors 1..5: truncation toward zero on magnitude.
    // 2^16 - 1 is a multiple of both 3 and 5, so split the magnitude at bit 16:
    // x / d = hi * ((2^16 - 1) / d) + (hi + lo) / d, the last by a short reciprocal.
    localparam int HALF_W = 16;
    localparam int HI_W   = SUM_W - HALF_W;
    localparam int FOLD_W = HI_W + 1;
    localparam int PROD_W = 2 * FOLD_W;
    localparam int REC_SH = 21;
    localparam logic [SUM_W-1:0]  K3   = SUM_W'(21845);
    localparam logic [SUM_W-1:0]  K5   = SUM_W'(13107);
    localparam logic [PROD_W-1:0] REC3 = PROD_W'(699051);
    localparam logic [PROD_W-1:0] REC5 = PROD_W'(419431);

    logic [SUM_W-1:0]                  mag;
    logic [HI_W-1:0]                   mag_hi;
    logic [FOLD_W-1:0]                 fold;
    logic [PROD_W-1:0]                 prod3, prod5;
    logic [SUM_W-1:0]                  quo;
    logic signed [rsv_pkg::DATA_W:0]   med_sum;
    logic signed [rsv_pkg::DATA_W-1:0] mean_v;

    always_comb
    begin
        mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        mag_hi = mag[SUM_W-1:HALF_W];
        fold   = FOLD_W'(mag_hi) + FOLD_W'(mag[HALF_W-1:0]);
        prod3  = PROD_W'(fold) * REC3;
        prod5  = PROD_W'(fold) * REC5;
        unique case (n_reg)
            3'd2:    quo = mag >> 1;
            3'd3:    quo = SUM_W'(mag_hi) * K3 + SUM_W'(prod3[PROD_W-1:REC_SH]);
            3'd4:    quo = mag >> 2;
            3'd5:    quo = SUM_W'(mag_hi) * K5 + SUM_W'(prod5[PROD_W-1:REC_SH]);
            default: quo = mag;
        endcase
        mean_v  = sum_reg[SUM_W-1] ? rsv_pkg::DATA_W'(-quo) : rsv_pkg::DATA_W'(quo);
        med_sum = (rsv_pkg::DATA_W+1)'(mida_reg) + (rsv_pkg::DATA_W+1)'(midb_reg);
        if (ovr_reg) begin
            result = ovr_val_reg;
        end else begin
            unique case (mode_reg)
                rsv_pkg::MODE_MEAN:   result = mean_v;
                rsv_pkg::MODE_MEDIAN: result = med_sum[rsv_pkg::DATA_W:1];
                rsv_pkg::MODE_MAX:    result = hi_reg;
                default:              result = lo_reg;
            endcase
        end
    end
endmodule

FILE: sv/redundant_sensor_vote_top.sv
// Top level of the redundant sensor vote: config registers, lanes, merge, output register.
// Depends on rsv_pkg, rsv_lane, rsv_merge.
// Takes one item per cycle while in_stall is low; a result passes the input regs, the
// merge/divide stage and the output register. Readings are range-checked as they are
// registered; each goes to one lane, which ranks it; the merge stage selects by rank and
// divides the sum by a constant count of one to five. Force wins over source-not-ready.
module redundant_sensor_vote_top #(
    parameter int NUM_SOURCES = rsv_pkg::NUM_SOURCES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rsv_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rsv_pkg::DATA_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rsv_pkg::MAX_SRC-1:0]           present_mask,
    input  logic signed [rsv_pkg::DATA_W-1:0]     reading_0,
    input  logic signed [rsv_pkg::DATA_W-1:0]     reading_1,
    input  logic signed [rsv_pkg::DATA_W-1:0]     reading_2,
    input  logic signed [rsv_pkg::DATA_W-1:0]     reading_3,
    input  logic signed [rsv_pkg::DATA_W-1:0]     reading_4,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rsv_pkg::DATA_W-1:0]     voted_value
);
    localparam int M = rsv_pkg::MAX_SRC;

    logic [1:0]                        mode_reg;
    logic                              rce_reg, fe_reg, sr_reg;
    logic signed [rsv_pkg::DATA_W-1:0] hi_reg, lo_reg, fb_reg, fv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= rsv_pkg::MODE_MEAN;
            rce_reg  <= 1'b1;
            hi_reg   <= rsv_pkg::HIGH_RESET;
            lo_reg   <= rsv_pkg::LOW_RESET;
            fb_reg   <= rsv_pkg::FALLBACK_RESET;
            fe_reg   <= 1'b1;
            fv_reg   <= rsv_pkg::FORCE_RESET;
            sr_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rsv_pkg::REG_OUTPUT_MODE:  mode_reg <= cfg_data[1:0];
                rsv_pkg::REG_RANGE_CHECK:  rce_reg  <= cfg_data[0];
                rsv_pkg::REG_HIGH_LIMIT:   hi_reg   <= cfg_data;
                rsv_pkg::REG_LOW_LIMIT:    lo_reg   <= cfg_data;
                rsv_pkg::REG_FALLBACK:     fb_reg   <= cfg_data;
                rsv_pkg::REG_FORCE_ENABLE: fe_reg   <= cfg_data[0];
                rsv_pkg::REG_FORCE_VALUE:  fv_reg   <= cfg_data;
                default:                   sr_reg   <= cfg_data[0];
            endcase
        end
    end

    // Pipeline: s1 (input regs), s2 (merge regs), s3 (output reg)
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    assign adv3     = ~v3_reg | ~out_stall;
    assign adv2     = ~v2_reg | adv3;
    assign adv1     = ~v1_reg | adv2;
    assign in_stall = ~adv1;

    logic                              keep1_reg [M];
    logic signed [rsv_pkg::DATA_W-1:0] val1_reg  [M];
    rsv_pkg::ctl_t                     ctl1_reg;
    logic signed [rsv_pkg::DATA_W-1:0] rd [M];

    assign rd[0] = reading_0;
    assign rd[1] = reading_1;
    assign rd[2] = reading_2;
    assign rd[3] = reading_3;
    assign rd[4] = reading_4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid) begin
            for (int i = 0; i < M; i++) begin
                keep1_reg[i] <= present_mask[i] && (i < NUM_SOURCES) &&
                    !(rce_reg && (rd[i] < lo_reg || rd[i] > hi_reg));
                val1_reg[i]  <= rd[i];
            end
            ctl1_reg.mode      <= mode_reg;
            ctl1_reg.force_en  <= fe_reg;
            ctl1_reg.src_ready <= sr_reg;
            ctl1_reg.force_val <= fv_reg;
            ctl1_reg.fallback  <= fb_reg;
        end
    end

    rsv_pkg::lane_t lanes [M];

    for (genvar g = 0; g < M; g++) begin : g_lane
        rsv_lane #(.LANE(g)) u_lane (
            .keep_in (keep1_reg),
            .values  (val1_reg),
            .lane    (lanes[g])
        );
    end

    logic signed [rsv_pkg::DATA_W-1:0] merged;

    rsv_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv2 && v1_reg),
        .lanes  (lanes),
        .ctl    (ctl1_reg),
        .result (merged)
    );

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg) begin
            voted_value <= merged;
        end
    end

    assign out_valid = v3_reg;

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(voted_value))
        else $error("result changed under stall");
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && v3_reg && out_stall |-> in_stall)
        else $error("input taken with full pipe");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !v3_reg |=> v3_reg)
        else $error("stage two result lost");
`endif
endmodule

FILE: test/tb_top.sv
// Testbench for redundant_sensor_vote_top: random and directed sensor sets, checked
// against an in-bench vote predictor. Depends on rsv_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rsv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rsv_pkg::DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [rsv_pkg::MAX_SRC-1:0] present_mask = '0;
    logic signed [rsv_pkg::DATA_W-1:0] reading_0 = '0, reading_1 = '0, reading_2 = '0;
    logic signed [rsv_pkg::DATA_W-1:0] reading_3 = '0, reading_4 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [rsv_pkg::DATA_W-1:0] voted_value;

    redundant_sensor_vote_top i_dut (.*);

    always #5 clk = ~clk;

    // Predictor copy of the register file
    logic [1:0] vote_mode = rsv_pkg::MODE_MEAN;
    logic range_on = 1'b1;
    logic signed [rsv_pkg::DATA_W-1:0] hi_lim = rsv_pkg::HIGH_RESET;
    logic signed [rsv_pkg::DATA_W-1:0] lo_lim = rsv_pkg::LOW_RESET;
    logic signed [rsv_pkg::DATA_W-1:0] fallback = rsv_pkg::FALLBACK_RESET;
    logic signed [rsv_pkg::DATA_W-1:0] force_val = rsv_pkg::FORCE_RESET;
    logic force_on = 1'b1, src_ready = 1'b1;

    logic signed [rsv_pkg::DATA_W-1:0] expected_votes[$];
    int errors = 0;
    int sent = 0;
    int voted = 0;
    bit idle_free = 1'b0;   // no random gaps on either side
    bit hold_rx = 1'b0;     // long receiver hold-off

    function automatic logic signed [rsv_pkg::DATA_W-1:0] predict_vote(
        input logic [4:0] mask, input logic signed [rsv_pkg::DATA_W-1:0] r [5]);
        longint kept[5];
        longint t, s, q;
        int n;
        n = 0;
        if (force_on) return force_val;
        if (!src_ready) return '0;
        for (int i = 0; i < 5 && i < rsv_pkg::NUM_SOURCES; i++) begin
            if (!mask[i]) continue;
            if (range_on && (r[i] < lo_lim || r[i] > hi_lim)) continue;
            kept[n] = r[i];
            n++;
        end
        if (n == 0) begin
            kept[0] = fallback;
            n = 1;
        end
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (kept[i] > kept[j]) begin
                    t = kept[i];
                    kept[i] = kept[j];
                    kept[j] = t;
                end
        case (vote_mode)
            rsv_pkg::MODE_MEAN: begin
                s = 0;
                for (int i = 0; i < n; i++) s += kept[i];
                return s / n;
            end
            rsv_pkg::MODE_MEDIAN: begin
                if (n % 2) return kept[n / 2];
                s = kept[n / 2 - 1] + kept[n / 2];
                q = s / 2;
                if (s < 0 && (s % 2) != 0) q -= 1;
                return q;
            end
            rsv_pkg::MODE_MAX: return kept[n - 1];
            default: return kept[0];
        endcase
    endfunction

    task automatic write_reg(input logic [rsv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rsv_pkg::DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rsv_pkg::REG_OUTPUT_MODE:  vote_mode = val[1:0];
            rsv_pkg::REG_RANGE_CHECK:  range_on = val[0];
            rsv_pkg::REG_HIGH_LIMIT:   hi_lim = val;
            rsv_pkg::REG_LOW_LIMIT:    lo_lim = val;
            rsv_pkg::REG_FALLBACK:     fallback = val;
            rsv_pkg::REG_FORCE_ENABLE: force_on = val[0];
            rsv_pkg::REG_FORCE_VALUE:  force_val = val;
            default:                   src_ready = val[0];
        endcase
    endtask

    // Drop the input and let the pipe drain before touching registers
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_votes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_set(input logic [4:0] mask,
                            input logic signed [rsv_pkg::DATA_W-1:0] r [5]);
        if (!idle_free) begin
            while ($urandom_range(99) < 20) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        present_mask <= mask;
        reading_0 <= r[0];
        reading_1 <= r[1];
        reading_2 <= r[2];
        reading_3 <= r[3];
        reading_4 <= r[4];
        expected_votes.push_back(predict_vote(mask, r));
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    function automatic logic signed [rsv_pkg::DATA_W-1:0] rand_reading();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $signed($urandom_range(400 << 16, 0)) - 32'sd3276800;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(input int count);
        logic signed [rsv_pkg::DATA_W-1:0] r [5];
        for (int k = 0; k < count; k++) begin
            for (int i = 0; i < 5; i++) r[i] = rand_reading();
            send_set(5'($urandom_range(31)), r);
        end
    endtask

    // Output side: random stalls, hold-off on demand, compare in order
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            voted++;
            if (expected_votes.size() == 0) begin
                $error("voted_value: no result expected, actual %0d", voted_value);
                errors++;
            end else if (voted_value !== expected_votes[0]) begin
                $error("voted_value: expected %0d actual %0d", expected_votes[0], voted_value);
                errors++;
                void'(expected_votes.pop_front());
            end else
                void'(expected_votes.pop_front());
        end
        out_stall <= hold_rx || (!idle_free && $urandom_range(99) < 20);
    end

    task automatic test_reset_defaults();
        logic signed [rsv_pkg::DATA_W-1:0] r [5];
        r = '{32'sd0, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd100};
        send_set(5'h1F, r);
        send_set(5'h00, r);
        wait_drained();
    endtask

    task automatic test_directed_modes();
        logic signed [rsv_pkg::DATA_W-1:0] r [5];
        write_reg(rsv_pkg::REG_FORCE_ENABLE, 0);
        write_reg(rsv_pkg::REG_SOURCE_READY, 0);
        r = '{32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5};
        send_set(5'h1F, r);
        wait_drained();
        write_reg(rsv_pkg::REG_SOURCE_READY, 1);
        for (int m = 0; m < 4; m++) begin
            wait_drained();
            write_reg(rsv_pkg::REG_OUTPUT_MODE, m);
            // limits inclusive: 50.0 and 300.0 kept, neighbors dropped
            r = '{rsv_pkg::LOW_RESET, rsv_pkg::HIGH_RESET, rsv_pkg::LOW_RESET - 1,
                  rsv_pkg::HIGH_RESET + 1, 32'sd6553601};
            send_set(5'h1F, r);
            r = '{-32'sd3, -32'sd6, 32'sd0, 32'sd0, 32'sd0};
            send_set(5'h00, r);                       // nothing present: fallback
            wait_drained();
            write_reg(rsv_pkg::REG_RANGE_CHECK, 0);
            r = '{-32'sd3, -32'sd6, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sh8000_0000};
            send_set(5'h03, r);                       // even count, negative odd sum
            send_set(5'h0C, r);
            send_set(5'h1F, r);
            send_set(5'h10, r);
            wait_drained();
            write_reg(rsv_pkg::REG_RANGE_CHECK, 1);
        end
        // low above high drops everything
        write_reg(rsv_pkg::REG_LOW_LIMIT, 32'sd100);
        write_reg(rsv_pkg::REG_HIGH_LIMIT, -32'sd100);
        write_reg(rsv_pkg::REG_FALLBACK, 32'sh8000_0000);
        r = '{32'sd0, 32'sd5, -32'sd5, 32'sd100, -32'sd100};
        send_set(5'h1F, r);
        wait_drained();
        write_reg(rsv_pkg::REG_FORCE_VALUE, 32'sh7FFF_FFFF);
        write_reg(rsv_pkg::REG_FORCE_ENABLE, 1);
        write_reg(rsv_pkg::REG_SOURCE_READY, 0);      // force wins
        send_set(5'h1F, r);
        wait_drained();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 16; phase++) begin
            wait_drained();
            write_reg(rsv_pkg::REG_OUTPUT_MODE, phase % 4);
            write_reg(rsv_pkg::REG_RANGE_CHECK, $urandom_range(1));
            write_reg(rsv_pkg::REG_LOW_LIMIT, (phase == 5) ? 32'h8000_0000 :
                      $signed($urandom_range(200 << 16)) - 32'sd3276800);
            write_reg(rsv_pkg::REG_HIGH_LIMIT, (phase == 5) ? 32'h7FFF_FFFF :
                      $signed($urandom_range(400 << 16)));
            write_reg(rsv_pkg::REG_FALLBACK, $urandom);
            write_reg(rsv_pkg::REG_FORCE_VALUE, $urandom);
            write_reg(rsv_pkg::REG_FORCE_ENABLE, 32'($urandom_range(9) == 0));
            write_reg(rsv_pkg::REG_SOURCE_READY, 32'($urandom_range(9) != 0));
            idle_free = (phase == 10);
            send_random(60);
        end
        idle_free = 1'b0;
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (60) @(posedge clk);
                hold_rx = 1'b0;
            end
            send_random(40);
        join
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_modes();
        write_reg(rsv_pkg::REG_FORCE_ENABLE, 0);
        write_reg(rsv_pkg::REG_SOURCE_READY, 1);
        test_backpressure();
        test_random_settings();
        wait_drained();
        repeat (10) @(posedge clk);
        $display("Covered %0d sensor sets over all vote modes, limits, force and not-ready",
                 sent);
        $display("and %0d checked votes, with random stalls and a long output hold-off.", voted);
        if (errors == 0 && expected_votes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
